// File: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

   // Default sizes, handed to the top level parameters
   localparam int BUCKETS_DEF    = 8;
   localparam int POOL_NODES_DEF = 64;

   // Fixed field widths
   localparam int KEY_W = 16;
   localparam int PAY_W = 32;
   localparam int POS_W = 7;

   // Position saturates at the top of its field
   localparam int POS_MAX = 127;

   // Operation codes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_FIND   = 1'b1
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_LINK,
      ST_WALK,
      ST_RESP
   } state_type;

   // Strobes from the sequencer to the table storage
   typedef struct packed {
      logic head_rd;
      logic head_wr;
      logic node_rd;
      logic node_wr;
   } store_ctl_type;

endpackage

// File: rtl/cht_if.sv
// ----------------------------------------------------------------------------
// cht_req_if / cht_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cht_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [cht_pkg::KEY_W-1:0]   key;
   logic [cht_pkg::PAY_W-1:0]   payload;

   modport source (output valid, output operation, output key, output payload,
                   input ready);
   modport sink   (input valid, input operation, input key, input payload,
                   output ready);
endinterface

interface cht_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [cht_pkg::POS_W-1:0]   position;
   logic [cht_pkg::PAY_W-1:0]   result_payload;
   logic                        pool_full;

   modport source (output valid, output found, output position,
                   output result_payload, output pool_full, input ready);
   modport sink   (input valid, input found, input position,
                   input result_payload, input pool_full, output ready);
endinterface

// File: rtl/cht_hash.sv
// ----------------------------------------------------------------------------
// cht_hash
// Bucket index unit: key mod BUCKETS by reciprocal multiplication, then a
// multiply-back and subtract, one registered step per cycle.
// ----------------------------------------------------------------------------
module cht_hash #(
   parameter int BUCKETS = cht_pkg::BUCKETS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cht_pkg::KEY_W-1:0]  key,
   output logic                       done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LOG_B  = $clog2(BUCKETS);
   localparam int SHIFT  = cht_pkg::KEY_W + LOG_B;
   localparam int RCP_W  = cht_pkg::KEY_W + 1;
   localparam int PROD_W = cht_pkg::KEY_W + RCP_W;
   // ceil(2^SHIFT / BUCKETS) gives the exact quotient for every 16-bit key
   localparam logic [63:0] RCP_FULL =
      ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

   logic [cht_pkg::KEY_W-1:0] key_ff;
   logic [cht_pkg::KEY_W-1:0] quo_ff;
   logic [cht_pkg::KEY_W-1:0] quo_in;
   logic [PROD_W-1:0]         prod;
   logic [cht_pkg::KEY_W-1:0] back;
   logic [BKT_W-1:0]          rem_ff;
   logic [BKT_W-1:0]          rem_in;
   logic                      mul_ff;
   logic                      sub_ff;
   logic                      done_ff;

   // Quotient by reciprocal multiply
   assign prod   = PROD_W'(key_ff) * PROD_W'(RCP);
   assign quo_in = cht_pkg::KEY_W'(prod >> SHIFT);

   // Remainder: key minus quotient times bucket count, always below BUCKETS
   assign back   = quo_ff * cht_pkg::KEY_W'(BUCKETS);
   assign rem_in = BKT_W'(key_ff - back);

   // Control: start, multiply, subtract, done
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         sub_ff  <= mul_ff;
         done_ff <= sub_ff;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         key_ff <= key;
      end
      if (mul_ff) begin
         quo_ff <= quo_in;
      end
      if (sub_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

// File: rtl/cht_store.sv
// ----------------------------------------------------------------------------
// cht_store
// Bucket head memory with per-bucket valid bits, and the node pool memory
// (key, payload, next link). Reads are registered.
// ----------------------------------------------------------------------------
module cht_store #(
   parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
   parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cht_pkg::store_ctl_type        ctl,
   input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0]          bucket,
   input  logic [((POOL_NODES > 1) ? $clog2(POOL_NODES) : 1)-1:0]    head_wdata,
   output logic [((POOL_NODES > 1) ? $clog2(POOL_NODES) : 1)-1:0]    head_rdata,
   output logic                          head_valid,
   input  logic [((POOL_NODES > 1) ? $clog2(POOL_NODES) : 1)-1:0]    node_waddr,
   input  logic [cht_pkg::KEY_W-1:0]     node_wkey,
   input  logic [cht_pkg::PAY_W-1:0]     node_wpay,
   input  logic [((POOL_NODES > 1) ? $clog2(POOL_NODES) : 1)-1:0]    node_wnext,
   input  logic                          node_wnext_valid,
   input  logic [((POOL_NODES > 1) ? $clog2(POOL_NODES) : 1)-1:0]    node_raddr,
   output logic [cht_pkg::KEY_W-1:0]     node_rkey,
   output logic [cht_pkg::PAY_W-1:0]     node_rpay,
   output logic [((POOL_NODES > 1) ? $clog2(POOL_NODES) : 1)-1:0]    node_rnext,
   output logic                          node_rnext_valid
);

   localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int WORD_W = cht_pkg::KEY_W + cht_pkg::PAY_W + NODE_W + 1;

   logic [NODE_W-1:0]  head_mem [BUCKETS];
   logic [NODE_W-1:0]  head_rd_ff;
   logic [BUCKETS-1:0] head_valid_ff;
   logic [WORD_W-1:0]  node_mem [POOL_NODES];
   logic [WORD_W-1:0]  node_rd_ff;

   // Head memory
   always_ff @(posedge clock) begin
      if (ctl.head_wr) begin
         head_mem[bucket] <= head_wdata;
      end
      if (ctl.head_rd) begin
         head_rd_ff <= head_mem[bucket];
      end
   end

   // Chain valid bits, all chains empty after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
      end else if (ctl.head_wr) begin
         head_valid_ff[bucket] <= 1'b1;
      end
   end

   // Node pool memory
   always_ff @(posedge clock) begin
      if (ctl.node_wr) begin
         node_mem[node_waddr] <= {node_wkey, node_wpay, node_wnext, node_wnext_valid};
      end
      if (ctl.node_rd) begin
         node_rd_ff <= node_mem[node_raddr];
      end
   end

   assign head_rdata = head_rd_ff;
   assign head_valid = head_valid_ff[bucket];
   assign {node_rkey, node_rpay, node_rnext, node_rnext_valid} = node_rd_ff;

endmodule

// File: rtl/chained_hash_table_top.sv
// ----------------------------------------------------------------------------
// chained_hash_table_top
// Hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per handshake: operation (insert or find), key
//   and payload. rsp_ch returns exactly one item per request, in order.
//   Insert puts a new node at the head of bucket (key mod BUCKETS); when
//   all POOL_NODES nodes are taken it changes nothing and reports pool_full.
//   Find walks the chain newest first and reports found, the 1-based
//   position of the first match (saturating at 127) and its payload.
// Timing:
//   One item at a time. Steps in order: bucket index (reciprocal multiply,
//   then multiply-back and subtract, then handoff), head read, link or
//   first node read, for a find the walk over the chain, one node per
//   cycle through the node memory read port (worst case the pool), then
//   the result register.
// Reset:
//   Synchronous; all chains empty and the pool unused. Node memory is not
//   cleared, it is only read after being written.
// Stall:
//   The result waits in an output register; the next request is accepted
//   meanwhile and its result is held back until the register frees.
// ----------------------------------------------------------------------------
module chained_hash_table_top #(
   parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
   parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   cht_req_if.sink  req_ch,
   cht_rsp_if.source rsp_ch
);

   localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int CNT_W  = $clog2(POOL_NODES + 1);
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int EXT_W  = (CNT_W > cht_pkg::POS_W) ? CNT_W : cht_pkg::POS_W;

   cht_pkg::state_type     state_ff;
   cht_pkg::state_type     state_in;
   cht_pkg::store_ctl_type store_ctl;

   logic                       accept;
   logic                       hash_start;
   logic                       hash_done;
   logic [BKT_W-1:0]           bucket;

   cht_pkg::op_type            op_ff;
   logic [cht_pkg::KEY_W-1:0]  key_ff;
   logic [cht_pkg::PAY_W-1:0]  pay_ff;
   logic [CNT_W-1:0]           used_ff;
   logic [CNT_W-1:0]           steps_ff;
   logic                       hit_ff;
   logic [cht_pkg::PAY_W-1:0]  hit_pay_ff;
   logic                       full_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_found_ff;
   logic [cht_pkg::POS_W-1:0]  rsp_pos_ff;
   logic [cht_pkg::PAY_W-1:0]  rsp_pay_ff;
   logic                       rsp_full_ff;

   logic [NODE_W-1:0]          head_rdata;
   logic                       head_valid;
   logic [NODE_W-1:0]          node_raddr;
   logic [cht_pkg::KEY_W-1:0]  node_rkey;
   logic [cht_pkg::PAY_W-1:0]  node_rpay;
   logic [NODE_W-1:0]          node_rnext;
   logic                       node_rnext_valid;

   logic                       pool_done;
   logic                       key_hit;
   logic                       out_free;
   logic [EXT_W-1:0]           steps_ext;
   logic [cht_pkg::POS_W-1:0]  pos_sat;

   assign accept    = req_ch.valid && req_ch.ready;
   assign pool_done = (used_ff == CNT_W'(POOL_NODES));
   assign key_hit   = (node_rkey == key_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Saturated chain position
   assign steps_ext = EXT_W'(steps_ff);
   assign pos_sat   = (steps_ext > EXT_W'(cht_pkg::POS_MAX)) ?
                      cht_pkg::POS_W'(cht_pkg::POS_MAX) : cht_pkg::POS_W'(steps_ext);

   // Bucket index unit
   cht_hash #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_ch.key),
      .done   (hash_done),
      .bucket (bucket)
   );

   // Head and node storage
   cht_store #(
      .BUCKETS    (BUCKETS),
      .POOL_NODES (POOL_NODES)
   ) u_store (
      .clock            (clock),
      .reset            (reset),
      .ctl              (store_ctl),
      .bucket           (bucket),
      .head_wdata       (used_ff[NODE_W-1:0]),
      .head_rdata       (head_rdata),
      .head_valid       (head_valid),
      .node_waddr       (used_ff[NODE_W-1:0]),
      .node_wkey        (key_ff),
      .node_wpay        (pay_ff),
      .node_wnext       (head_rdata),
      .node_wnext_valid (head_valid),
      .node_raddr       (node_raddr),
      .node_rkey        (node_rkey),
      .node_rpay        (node_rpay),
      .node_rnext       (node_rnext),
      .node_rnext_valid (node_rnext_valid)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cht_pkg::ST_IDLE: begin
            if (accept) state_in = cht_pkg::ST_HASH;
         end
         cht_pkg::ST_HASH: begin
            if (hash_done) state_in = cht_pkg::ST_HEAD;
         end
         cht_pkg::ST_HEAD: begin
            state_in = cht_pkg::ST_LINK;
         end
         cht_pkg::ST_LINK: begin
            if (op_ff == cht_pkg::OP_FIND && head_valid) begin
               state_in = cht_pkg::ST_WALK;
            end else begin
               state_in = cht_pkg::ST_RESP;
            end
         end
         cht_pkg::ST_WALK: begin
            if (key_hit || !node_rnext_valid) state_in = cht_pkg::ST_RESP;
         end
         cht_pkg::ST_RESP: begin
            if (out_free) state_in = cht_pkg::ST_IDLE;
         end
         default: state_in = cht_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      store_ctl  = '0;
      hash_start = 1'b0;
      node_raddr = node_rnext;
      unique case (state_ff)
         cht_pkg::ST_IDLE: begin
            hash_start = accept;
         end
         cht_pkg::ST_HEAD: begin
            store_ctl.head_rd = 1'b1;
         end
         cht_pkg::ST_LINK: begin
            node_raddr = head_rdata;
            if (op_ff == cht_pkg::OP_INSERT) begin
               store_ctl.node_wr = !pool_done;
               store_ctl.head_wr = !pool_done;
            end else begin
               store_ctl.node_rd = head_valid;
            end
         end
         cht_pkg::ST_WALK: begin
            store_ctl.node_rd = !key_hit && node_rnext_valid;
         end
         default: begin
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cht_pkg::ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == cht_pkg::ST_LINK && op_ff == cht_pkg::OP_INSERT && !pool_done) begin
            used_ff <= used_ff + CNT_W'(1);
         end
      end
   end

   // Item registers and walk bookkeeping
   always_ff @(posedge clock) begin
      unique case (state_ff)
         cht_pkg::ST_IDLE: begin
            if (accept) begin
               op_ff   <= cht_pkg::op_type'(req_ch.operation);
               key_ff  <= req_ch.key;
               pay_ff  <= req_ch.payload;
               hit_ff  <= 1'b0;
               full_ff <= 1'b0;
            end
         end
         cht_pkg::ST_LINK: begin
            steps_ff <= CNT_W'(1);
            if (op_ff == cht_pkg::OP_INSERT) full_ff <= pool_done;
         end
         cht_pkg::ST_WALK: begin
            if (key_hit) begin
               hit_ff     <= 1'b1;
               hit_pay_ff <= node_rpay;
            end else begin
               steps_ff <= steps_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == cht_pkg::ST_RESP && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cht_pkg::ST_RESP && out_free) begin
         rsp_found_ff <= hit_ff;
         rsp_pos_ff   <= hit_ff ? pos_sat : '0;
         rsp_pay_ff   <= hit_ff ? hit_pay_ff : '0;
         rsp_full_ff  <= full_ff;
      end
   end

   assign req_ch.ready          = (state_ff == cht_pkg::ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.position       = rsp_pos_ff;
   assign rsp_ch.result_payload = rsp_pay_ff;
   assign rsp_ch.pool_full      = rsp_full_ff;

endmodule

// File: rtl/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table, bound to the top level.
// ----------------------------------------------------------------------------
module cht_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       found,
   input logic [cht_pkg::POS_W-1:0]  position,
   input logic [cht_pkg::PAY_W-1:0]  result_payload,
   input logic                       pool_full
);

   // A stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(position)
                                  && $stable(result_payload) && $stable(pool_full))
   else $error("stalled result item changed");

   // No result item in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("result item right after reset");

   // A rejected insert never reports a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pool_full |-> !found)
   else $error("pool full together with found");

   // A miss carries zero position and payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> position == '0 && result_payload == '0)
   else $error("miss with nonzero position or payload");

   // A hit has a position of at least one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found |-> position != '0)
   else $error("hit with zero position");

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .found          (rsp_ch.found),
   .position       (rsp_ch.position),
   .result_payload (rsp_ch.result_payload),
   .pool_full      (rsp_ch.pool_full)
);
